FILE: rtl/isrn_pkg.sv
// shared types and constants of the newton square root block
package isrn_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned ROOT_W    = 16;
	localparam int unsigned MSB_W     = $clog2(DATA_W);
	localparam int unsigned MAX_STEPS = 64;
	localparam int unsigned STEP_W    = $clog2(MAX_STEPS + 1);

	typedef struct packed {
		logic load;
		logic scan;
		logic init;
		logic div_start;
		logic update;
		logic emit;
	} isrn_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic iterate;
		logic div_busy;
		logic div_done;
	} isrn_sts_t;

endpackage

FILE: rtl/isrn_div.sv
// restoring unsigned divider, one quotient bit per cycle
module isrn_div
	import isrn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] num,
	input  logic [DATA_W-1:0] den,
	output logic              busy,
	output logic              done,
	output logic [DATA_W-1:0] quot
);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quot_q;
	logic [DATA_W-1:0] den_q;
	logic [MSB_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W-1:0] diff;
	logic              fits;

	assign shifted = {rem_q, quot_q[DATA_W-1]};
	assign fits    = shifted >= {1'b0, den_q};
	assign diff    = shifted[DATA_W-1:0] - den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MSB_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= num;
			den_q  <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q  <= diff;
				quot_q <= {quot_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[DATA_W-1:0];
				quot_q <= {quot_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: rtl/isrn_dp.sv
// datapath: leading one scan, newton estimate registers, divider, result register
module isrn_dp
	import isrn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  isrn_cmd_t         cmd,
	input  logic [DATA_W-1:0] radicand,
	output isrn_sts_t         sts,
	output logic [ROOT_W-1:0] root
);

	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] t_q;
	logic [MSB_W-1:0]  msb_q;
	logic [DATA_W-1:0] est_q;
	logic [DATA_W-1:0] prev_q;
	logic [STEP_W-1:0] steps_q;
	logic [ROOT_W-1:0] root_q;
	logic [DATA_W-1:0] quot;
	logic [DATA_W-1:0] delta;
	logic [DATA_W-1:0] sum;
	logic              div_busy;
	logic              div_done;

	isrn_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (x_q),
		.den   (est_q),
		.busy  (div_busy),
		.done  (div_done),
		.quot  (quot)
	);

	assign delta = est_q - prev_q;
	assign sum   = prev_q + quot;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= radicand;
			t_q     <= radicand;
			msb_q   <= '0;
			steps_q <= '0;
		end
		if (cmd.scan) begin
			t_q   <= t_q >> 1;
			msb_q <= msb_q + 1'b1;
		end
		if (cmd.init) begin
			est_q  <= x_q >> msb_q[MSB_W-1:1];
			prev_q <= x_q;
		end
		if (cmd.div_start) begin
			prev_q  <= est_q;
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.update) begin
			est_q <= {1'b0, sum[DATA_W-1:1]};
		end
		if (cmd.emit) begin
			root_q <= est_q[ROOT_W-1:0];
		end
	end

	assign sts.scan_done = (t_q[DATA_W-1:1] == '0);
	assign sts.iterate   = (delta > DATA_W'(1)) && (steps_q < STEP_W'(MAX_STEPS));
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;
	assign root          = root_q;

endmodule

FILE: rtl/isrn_ctrl.sv
// controller state machine and stream handshakes
module isrn_ctrl
	import isrn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  isrn_sts_t sts,
	output isrn_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					cmd.init = 1'b1;
					state_d  = ST_CHECK;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_CHECK: begin
				if (sts.iterate) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.update = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

FILE: rtl/integer_square_root_newton_top.sv
// Integer square root by Newton iteration: one 32-bit radicand beat in, one
// 16-bit root beat out. The block works on one radicand at a time. An item
// is loaded, then its leading one bit is found (one bit per cycle) and the
// first estimate is set; each Newton step is a check and a division in the
// serial restoring divider (one quotient bit per cycle), after which the
// quotient is taken into the estimate. A final check follows, then the
// result register is loaded once the output register is free. The next
// radicand is taken while the previous root still waits in the output
// register.
// Radicands 0 to 3 return themselves; 0xFFFFFFFF returns 0 (65536 truncated).
module integer_square_root_newton_top
	import isrn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // radicand
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [ROOT_W-1:0] m_tdata   // root
);

	isrn_cmd_t cmd;
	isrn_sts_t sts;

	isrn_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	isrn_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.radicand(s_tdata),
		.sts     (sts),
		.root    (m_tdata)
	);

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("new beat accepted while an item is in work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("result register overwritten before its beat was taken");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");
`endif

endmodule

FILE: tb/integer_square_root_newton_top_test.sv
// testbench for the newton square root block: directed and random radicands checked per beat
`timescale 1ns / 1ps

module integer_square_root_newton_top_test;
	import isrn_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 10_000_000;
	localparam int unsigned DRAIN_CYCLES = 500;
	localparam int unsigned RANDOM_ITEMS = 1430;
	localparam int unsigned PAUSE_EVERY  = 350;

	typedef struct packed {
		logic [DATA_W-1:0] radicand;
		logic              typed;
		logic [ROOT_W-1:0] root;
	} root_row_t;

	typedef struct packed {
		logic [DATA_W-1:0] radicand;
		logic [ROOT_W-1:0] root;
	} root_exp_t;

	localparam int unsigned DIRECTED_N = 22;

	root_row_t directed_rows [DIRECTED_N] = '{
		'{32'h0000_0000, 1'b1, 16'h0000},
		'{32'h0000_0001, 1'b1, 16'h0001},
		'{32'h0000_0002, 1'b1, 16'h0002},
		'{32'h0000_0003, 1'b1, 16'h0003},
		'{32'hFFFF_FFFF, 1'b1, 16'h0000},
		'{32'h0000_0004, 1'b0, 16'h0000},
		'{32'h0000_0008, 1'b0, 16'h0000},
		'{32'h0000_000F, 1'b0, 16'h0000},
		'{32'h0000_0010, 1'b0, 16'h0000},
		'{32'h0000_0018, 1'b0, 16'h0000},
		'{32'h0000_0019, 1'b0, 16'h0000},
		'{32'h0000_0063, 1'b0, 16'h0000},
		'{32'h0000_0064, 1'b0, 16'h0000},
		'{32'h0000_00FF, 1'b0, 16'h0000},
		'{32'h0000_0100, 1'b0, 16'h0000},
		'{32'h000F_4240, 1'b0, 16'h0000},
		'{32'h4000_0000, 1'b0, 16'h0000},
		'{32'h7FFF_FFFF, 1'b0, 16'h0000},
		'{32'h8000_0000, 1'b0, 16'h0000},
		'{32'h5555_5555, 1'b0, 16'h0000},
		'{32'hAAAA_AAAA, 1'b0, 16'h0000},
		'{32'hFFFE_0001, 1'b0, 16'h0000}
	};

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [ROOT_W-1:0] m_tdata;

	root_exp_t   pending_roots [$];
	root_exp_t   head_root;
	int unsigned fail_count;
	int unsigned roots_checked;
	int unsigned radicands_sent;

	integer_square_root_newton_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [ROOT_W-1:0] newton_root16(logic [DATA_W-1:0] x);
		logic [DATA_W-1:0] t;
		logic [DATA_W-1:0] est;
		logic [DATA_W-1:0] prev;
		logic [DATA_W-1:0] quot;
		logic [DATA_W-1:0] sum;
		logic [DATA_W-1:0] diff;
		int unsigned       lead;
		int unsigned       steps;
		t = x >> 1;
		lead = 0;
		while (t != '0) begin
			lead++;
			t = t >> 1;
		end
		est = x >> (lead >> 1);
		prev = x;
		steps = 0;
		diff = est - prev;
		while (diff > 32'd1 && steps < MAX_STEPS) begin
			prev = est;
			quot = (prev == '0) ? '1 : x / prev;
			sum = prev + quot;
			est = sum >> 1;
			steps++;
			diff = est - prev;
		end
		return est[ROOT_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] pick_radicand();
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] k;
		int unsigned       b;
		int unsigned       sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2: begin
				v = $urandom;
			end
			3, 4: begin
				b = $urandom_range(0, DATA_W - 1);
				v = $urandom;
				v = v & ((b == DATA_W - 1) ? '1 : ((32'd1 << (b + 1)) - 32'd1));
				v = v | (32'd1 << b);
			end
			5, 6: begin
				k = $urandom_range(0, 65535);
				v = k * k + $urandom_range(0, 2) - 32'd1;
			end
			7: begin
				v = $urandom_range(0, 300);
			end
			8: begin
				v = 32'hFFFF_FFFF - $urandom_range(0, 300);
			end
			default: begin
				b = $urandom_range(0, DATA_W - 1);
				v = (32'd1 << b) + $urandom_range(0, 2) - 32'd1;
			end
		endcase
		return v;
	endfunction

	// drive one beat from a falling edge, return at the falling edge after acceptance
	task automatic send_radicand(input logic [DATA_W-1:0] value, input logic [ROOT_W-1:0] want);
		root_exp_t e;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		e.radicand = value;
		e.root     = want;
		pending_roots.push_back(e);
		radicands_sent++;
		@(negedge clk);
	endtask

	task automatic sender_gap();
		int unsigned gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_roots.size() == 0) begin
				$error("unexpected root beat: actual %h", m_tdata);
				fail_count++;
			end else begin
				head_root = pending_roots.pop_front();
				if (m_tdata !== head_root.root) begin
					$error("root mismatch for radicand %h: expected %h, actual %h",
						head_root.radicand, head_root.root, m_tdata);
					fail_count++;
				end
				roots_checked++;
			end
		end
	end

	initial begin
		int unsigned mode;
		int unsigned run;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			run  = $urandom_range(5, 400);
			repeat (run) begin
				@(negedge clk);
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= ($urandom_range(0, 1) == 1);
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int unsigned burst;
		int unsigned n;
		logic [DATA_W-1:0] v;
		fail_count     = 0;
		roots_checked  = 0;
		radicands_sent = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < DIRECTED_N; i++) begin
			send_radicand(directed_rows[i].radicand,
				directed_rows[i].typed ? directed_rows[i].root
					: newton_root16(directed_rows[i].radicand));
			if ($urandom_range(0, 1) == 1) sender_gap();
		end

		n = 0;
		while (n < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 8);
			repeat (burst) begin
				if (n < RANDOM_ITEMS) begin
					v = pick_radicand();
					send_radicand(v, newton_root16(v));
					n++;
					if (n % PAUSE_EVERY == 0) begin
						// hold off until the block has drained
						s_tvalid <= 1'b0;
						@(negedge clk);
						while (pending_roots.size() != 0) @(negedge clk);
					end
				end
			end
			sender_gap();
		end
		s_tvalid <= 1'b0;

		while (pending_roots.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d radicands (%0d directed, %0d random), checked %0d roots",
			radicands_sent, DIRECTED_N, RANDOM_ITEMS, roots_checked);
		$display("covered small values, powers of two, near-square and all-ones radicands");
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/isrn_pkg.sv
rtl/isrn_div.sv
rtl/isrn_dp.sv
rtl/isrn_ctrl.sv
rtl/integer_square_root_newton_top.sv
tb/integer_square_root_newton_top_test.sv
